@@ src/brs_pkg.sv @@
`timescale 1ns / 1ps

package brs_pkg;

    localparam int DEF_MAX_WIDTH    = 512;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_FRAC_BITS    = 8;
    localparam int DEF_MAX_CHANNELS = 4;

    // holds any image size up to the top of the parameter range
    localparam int CFG_DIM_BITS = 14;
    localparam int CHAN_BITS    = 3;
    localparam int N_BANKS      = 4;

    localparam logic [CHAN_BITS-1:0] CHAN_RESET = 3'd3;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic [CFG_DIM_BITS-1:0] width;
        logic [CFG_DIM_BITS-1:0] height;
        logic [CHAN_BITS-1:0]    chan_count;
    } t_cfg;

    // which bank parity each of the four taps came from
    typedef struct packed {
        logic                 valid;
        logic [CHAN_BITS-1:0] chan_count;
        logic                 x0_odd;
        logic                 x1_odd;
        logic                 y0_odd;
        logic                 y1_odd;
    } t_tap_ctl;

endpackage

@@ src/bilinear_remap_sampler.sv @@
`timescale 1ns / 1ps

// Bilinear sampler over a stored source image.
// Command channel: an item is taken when start is high and busy is low.
// busy stays low, so one item can be taken every cycle. With i_cmd low the
// item stores i_write_pixel at (i_write_col, i_write_row) and gives no result.
// With i_cmd high it samples at (i_sample_x, i_sample_y), clamped into the
// configured image, and the blended pixel appears on o_pixel_out with
// o_result_valid high for one cycle, once it has passed the bank read,
// weight, product and sum registers.
// Results leave in the order the samples came in; there is no back-pressure.
// Throughput is one item per cycle: the image sits in four banks split by
// column and row parity, so the four taps of a sample take one read port each,
// and the blend runs as weight, product and sum stages.
// A write is visible to a sample in the very next cycle.
// Reset empties the pipeline and loads image_width, image_height and
// channel_count with their defaults; the image store is not cleared, and
// a pixel must be written before a sample reads it.
// Registers sit on the APB-style port at 0x0, 0x4 and 0x8; change them only
// while no sample is in flight.

module bilinear_remap_sampler
    import brs_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [8:0]         i_write_col,
    input  logic [7:0]         i_write_row,
    input  logic [31:0]        i_write_pixel,
    input  logic signed [17:0] i_sample_x,
    input  logic signed [16:0] i_sample_y,
    output logic               o_result_valid,
    output logic [31:0]        o_pixel_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int XH    = (XB > 1) ? XB - 1 : 1;
    localparam int YH    = (YB > 1) ? YB - 1 : 1;
    localparam int AW    = XH + YH;
    localparam int DEPTH = 1 << AW;

    logic                 item_acc;
    logic                 write_acc;
    logic                 sample_acc;
    logic                 cfg_wr;
    t_cfg                 r_cfg;
    logic [CFG_DIM_BITS-1:0] n_width;
    logic [CFG_DIM_BITS-1:0] n_height;
    logic [CHAN_BITS-1:0] n_chan;

    logic [N_BANKS-1:0]   bank_we;
    logic [AW-1:0]        bank_waddr;
    logic [N_BANKS-1:0]   bank_re;
    logic [AW-1:0]        bank_raddr [N_BANKS];
    logic [31:0]          bank_rdata [N_BANKS];
    t_tap_ctl             tap_ctl;
    logic [FRAC_BITS-1:0] tap_fx;
    logic [FRAC_BITS-1:0] tap_fy;

    assign busy       = 1'b0;
    assign pready     = 1'b1;
    assign item_acc   = start && !busy;
    assign write_acc  = item_acc && (i_cmd == CMD_WRITE);
    assign sample_acc = item_acc && (i_cmd == CMD_SAMPLE);
    assign cfg_wr     = psel && penable && pwrite && pready;

    // saturate register writes into their legal ranges
    always_comb begin
        n_width  = CFG_DIM_BITS'(pwdata[9:0]);
        n_height = CFG_DIM_BITS'(pwdata[8:0]);
        n_chan   = pwdata[2:0];
        if (n_width == '0) begin
            n_width = CFG_DIM_BITS'(1);
        end else if (n_width > CFG_DIM_BITS'(MAX_WIDTH)) begin
            n_width = CFG_DIM_BITS'(MAX_WIDTH);
        end
        if (n_height == '0) begin
            n_height = CFG_DIM_BITS'(1);
        end else if (n_height > CFG_DIM_BITS'(MAX_HEIGHT)) begin
            n_height = CFG_DIM_BITS'(MAX_HEIGHT);
        end
        if (n_chan == '0) begin
            n_chan = CHAN_BITS'(1);
        end else if (n_chan > CHAN_BITS'(MAX_CHANNELS)) begin
            n_chan = CHAN_BITS'(MAX_CHANNELS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width      <= CFG_DIM_BITS'(MAX_WIDTH);
            r_cfg.height     <= CFG_DIM_BITS'(MAX_HEIGHT);
            r_cfg.chan_count <= CHAN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:   r_cfg.width      <= n_width;
                REG_IMAGE_HEIGHT:  r_cfg.height     <= n_height;
                REG_CHANNEL_COUNT: r_cfg.chan_count <= n_chan;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:   prdata = 32'(r_cfg.width);
            REG_IMAGE_HEIGHT:  prdata = 32'(r_cfg.height);
            REG_CHANNEL_COUNT: prdata = 32'(r_cfg.chan_count);
            default:           prdata = '0;
        endcase
    end

    brs_addr_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_addr_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_write     (write_acc),
        .i_sample    (sample_acc),
        .i_cfg       (r_cfg),
        .i_write_col (i_write_col),
        .i_write_row (i_write_row),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .o_we        (bank_we),
        .o_waddr     (bank_waddr),
        .o_re        (bank_re),
        .o_raddr     (bank_raddr),
        .o_ctl       (tap_ctl),
        .o_fx        (tap_fx),
        .o_fy        (tap_fy)
    );

    for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
        brs_ram #(
            .WIDTH (32),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (bank_waddr),
            .i_wdata (i_write_pixel),
            .i_re    (bank_re[b]),
            .i_raddr (bank_raddr[b]),
            .o_rdata (bank_rdata[b])
        );
    end

    brs_blend #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tap_ctl),
        .i_fx        (tap_fx),
        .i_fy        (tap_fy),
        .i_bank_data (bank_rdata),
        .o_valid     (o_result_valid),
        .o_pixel     (o_pixel_out)
    );

    a_result_has_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(sample_acc, 4))
        else $error("result strobe without a sample four cycles before");

    a_sample_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_acc |-> ##4 o_result_valid)
        else $error("sample transfer gave no result");

    a_write_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        write_acc |-> ##4 !o_result_valid)
        else $error("pixel write produced a result");

endmodule

@@ src/brs_ram.sv @@
`timescale 1ns / 1ps

module brs_ram
    import brs_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT / N_BANKS,
    localparam int AB   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AB-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AB-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/brs_addr_gen.sv @@
`timescale 1ns / 1ps

module brs_addr_gen
    import brs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int XB = $clog2(MAX_WIDTH),
    localparam int YB = $clog2(MAX_HEIGHT),
    localparam int XH = (XB > 1) ? XB - 1 : 1,
    localparam int YH = (YB > 1) ? YB - 1 : 1,
    localparam int AW = XH + YH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_write,
    input  logic                 i_sample,
    input  t_cfg                 i_cfg,
    input  logic [8:0]           i_write_col,
    input  logic [7:0]           i_write_row,
    input  logic signed [17:0]   i_sample_x,
    input  logic signed [16:0]   i_sample_y,
    output logic [N_BANKS-1:0]   o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [N_BANKS-1:0]   o_re,
    output logic [AW-1:0]        o_raddr [N_BANKS],
    output t_tap_ctl             o_ctl,
    output logic [FRAC_BITS-1:0] o_fx,
    output logic [FRAC_BITS-1:0] o_fy
);

    logic [31:0]          col_w;
    logic [31:0]          row_w;
    logic                 in_store;
    logic signed [31:0]   sx;
    logic signed [31:0]   sy;
    logic [31:0]          hi_x;
    logic [31:0]          hi_y;
    logic [31:0]          cx;
    logic [31:0]          cy;
    logic [XB-1:0]        x0;
    logic [XB-1:0]        x1;
    logic [YB-1:0]        y0;
    logic [YB-1:0]        y1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [XB:0]          col_sel [2];
    logic [YB:0]          row_sel [2];

    logic                 r_valid;
    t_tap_ctl             r_ctl;
    logic [FRAC_BITS-1:0] r_fx;
    logic [FRAC_BITS-1:0] r_fy;

    // write side: bank by column and row parity, halves address the bank
    always_comb begin
        col_w    = 32'(i_write_col);
        row_w    = 32'(i_write_row);
        in_store = (col_w < 32'(MAX_WIDTH)) && (row_w < 32'(MAX_HEIGHT));
        o_waddr  = {row_w[YH:1], col_w[XH:1]};
        for (int b = 0; b < N_BANKS; b++) begin
            o_we[b] = i_write && in_store && ({row_w[0], col_w[0]} == 2'(b));
        end
    end

    // clamp each axis into 0 .. (size-1) * 2^FRAC_BITS
    always_comb begin
        sx   = 32'(i_sample_x);
        sy   = 32'(i_sample_y);
        hi_x = (32'(i_cfg.width) - 32'd1) << FRAC_BITS;
        hi_y = (32'(i_cfg.height) - 32'd1) << FRAC_BITS;
        if (sx[31]) begin
            cx = '0;
        end else if ($unsigned(sx) > hi_x) begin
            cx = hi_x;
        end else begin
            cx = $unsigned(sx);
        end
        if (sy[31]) begin
            cy = '0;
        end else if ($unsigned(sy) > hi_y) begin
            cy = hi_y;
        end else begin
            cy = $unsigned(sy);
        end
        x0 = cx[XB+FRAC_BITS-1:FRAC_BITS];
        y0 = cy[YB+FRAC_BITS-1:FRAC_BITS];
        fx = cx[FRAC_BITS-1:0];
        fy = cy[FRAC_BITS-1:0];
        x1 = x0 + XB'(fx != '0);
        y1 = y0 + YB'(fy != '0);
    end

    // where x1 != x0 (y1 != y0), each bank holds exactly one of the columns x0, x1 (rows y0, y1)
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            col_sel[p] = (x0[0] == p[0]) ? {1'b0, x0} : {1'b0, x1};
            row_sel[p] = (y0[0] == p[0]) ? {1'b0, y0} : {1'b0, y1};
        end
        for (int b = 0; b < N_BANKS; b++) begin
            o_raddr[b] = {row_sel[b/2][YH:1], col_sel[b%2][XH:1]};
            o_re[b]    = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl.valid      <= 1'b0;
        r_ctl.chan_count <= i_cfg.chan_count;
        r_ctl.x0_odd     <= x0[0];
        r_ctl.x1_odd     <= x1[0];
        r_ctl.y0_odd     <= y0[0];
        r_ctl.y1_odd     <= y1[0];
        r_fx             <= fx;
        r_fy             <= fy;
    end

    always_comb begin
        o_ctl       = r_ctl;
        o_ctl.valid = r_valid;
    end

    assign o_fx = r_fx;
    assign o_fy = r_fy;

endmodule

@@ src/brs_blend.sv @@
`timescale 1ns / 1ps

module brs_blend
    import brs_pkg::*;
#(
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int WB = 2 * FRAC_BITS + 1,
    localparam int PB = 8 + 2 * FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tap_ctl             i_ctl,
    input  logic [FRAC_BITS-1:0] i_fx,
    input  logic [FRAC_BITS-1:0] i_fy,
    input  logic [31:0]          i_bank_data [N_BANKS],
    output logic                 o_valid,
    output logic [31:0]          o_pixel
);

    localparam logic [FRAC_BITS:0] S_ONE = (FRAC_BITS+1)'(1 << FRAC_BITS);
    localparam logic [PB+1:0]      ROUND = (PB+2)'(1 << (2 * FRAC_BITS - 1));

    logic [FRAC_BITS:0]     sfx;
    logic [FRAC_BITS:0]     sfy;
    logic [FRAC_BITS:0]     efx;
    logic [FRAC_BITS:0]     efy;
    logic [WB-1:0]          m_w [4];
    logic [1:0]             tap_bank [4];
    logic [PB-1:0]          n_prod [MAX_CHANNELS][4];
    logic [31:0]            n_pixel;

    logic                   r_v2;
    logic                   r_v3;
    logic                   r_valid;
    logic [WB-1:0]          r_w [4];
    logic [31:0]            r_pix [4];
    logic [MAX_CHANNELS-1:0] r_en2;
    logic [MAX_CHANNELS-1:0] r_en3;
    logic [PB-1:0]          r_prod [MAX_CHANNELS][4];
    logic [31:0]            r_pixel;

    // taps in order top-left, top-right, bottom-right, bottom-left
    always_comb begin
        efx = {1'b0, i_fx};
        efy = {1'b0, i_fy};
        sfx = S_ONE - efx;
        sfy = S_ONE - efy;
        m_w[0] = WB'(sfx) * WB'(sfy);
        m_w[1] = WB'(efx) * WB'(sfy);
        m_w[2] = WB'(efx) * WB'(efy);
        m_w[3] = WB'(sfx) * WB'(efy);
        tap_bank[0] = {i_ctl.y0_odd, i_ctl.x0_odd};
        tap_bank[1] = {i_ctl.y0_odd, i_ctl.x1_odd};
        tap_bank[2] = {i_ctl.y1_odd, i_ctl.x1_odd};
        tap_bank[3] = {i_ctl.y1_odd, i_ctl.x0_odd};
    end

    always_comb begin
        logic [8+WB-1:0] full;
        full = '0;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            for (int k = 0; k < 4; k++) begin
                full         = (8+WB)'(r_pix[k][8*c +: 8]) * (8+WB)'(r_w[k]);
                n_prod[c][k] = full[PB-1:0];
            end
        end
    end

    always_comb begin
        logic [PB+1:0] acc;
        acc     = '0;
        n_pixel = '0;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            acc = r_prod[c][0] + r_prod[c][1] + r_prod[c][2] + r_prod[c][3] + ROUND;
            n_pixel[8*c +: 8] = r_en3[c] ? acc[2*FRAC_BITS+7:2*FRAC_BITS] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v2    <= i_ctl.valid;
            r_v3    <= r_v2;
            r_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_w[k]   <= m_w[k];
            r_pix[k] <= i_bank_data[tap_bank[k]];
        end
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            r_en2[c] <= CHAN_BITS'(c) < i_ctl.chan_count;
        end
        r_en3   <= r_en2;
        r_prod  <= n_prod;
        r_pixel <= n_pixel;
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

@@ tb/sv/bilinear_remap_sampler_test.sv @@
`timescale 1ns / 1ps

module bilinear_remap_sampler_test;
    import brs_pkg::*;

    localparam int FRAC       = DEF_FRAC_BITS;
    localparam int ONE        = 1 << FRAC;
    localparam int STORE_W    = DEF_MAX_WIDTH;
    localparam int STORE_H    = DEF_MAX_HEIGHT;
    localparam int STALL_MAX  = 4000;
    localparam int TAIL_WAIT  = 8;

    class remap_predictor;
        bit [31:0]   image [0:STORE_W*STORE_H-1];
        int          width;
        int          height;
        int          chans;
        logic [31:0] pending_pixels[$];
        int          fails;

        function new();
            width  = DEF_MAX_WIDTH;
            height = DEF_MAX_HEIGHT;
            chans  = CHAN_RESET;
            fails  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            int v;
            case (idx)
                REG_IMAGE_WIDTH: begin
                    v     = value[9:0];
                    width = (v < 1) ? 1 : (v > STORE_W) ? STORE_W : v;
                end
                REG_IMAGE_HEIGHT: begin
                    v      = value[8:0];
                    height = (v < 1) ? 1 : (v > STORE_H) ? STORE_H : v;
                end
                REG_CHANNEL_COUNT: begin
                    v     = value[2:0];
                    chans = (v < 1) ? 1 : (v > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : v;
                end
                default: ;
            endcase
        endfunction

        // clamp the coordinate into the image and find the four taps
        function void locate(logic signed [17:0] sx, logic signed [16:0] sy,
                             output int x0, output int y0, output int x1,
                             output int y1, output int fx, output int fy);
            int cx, cy, lim_x, lim_y;
            cx    = sx;
            cy    = sy;
            lim_x = (width - 1) * ONE;
            lim_y = (height - 1) * ONE;
            cx    = (cx < 0) ? 0 : (cx > lim_x) ? lim_x : cx;
            cy    = (cy < 0) ? 0 : (cy > lim_y) ? lim_y : cy;
            x0    = cx >> FRAC;
            y0    = cy >> FRAC;
            fx    = cx & (ONE - 1);
            fy    = cy & (ONE - 1);
            x1    = x0 + ((fx != 0) ? 1 : 0);
            y1    = y0 + ((fy != 0) ? 1 : 0);
        endfunction

        function logic [31:0] blend_pixel(logic signed [17:0] sx, logic signed [16:0] sy);
            int          x0, y0, x1, y1, fx, fy, acc, c, k;
            int          wt [4];
            logic [31:0] tap [4];
            logic [31:0] res;
            locate(sx, sy, x0, y0, x1, y1, fx, fy);
            wt[0]  = (ONE - fx) * (ONE - fy);
            wt[1]  = fx * (ONE - fy);
            wt[2]  = fx * fy;
            wt[3]  = (ONE - fx) * fy;
            tap[0] = image[y0*STORE_W + x0];
            tap[1] = image[y0*STORE_W + x1];
            tap[2] = image[y1*STORE_W + x1];
            tap[3] = image[y1*STORE_W + x0];
            res    = '0;
            for (c = 0; c < chans; c++) begin
                acc = 0;
                for (k = 0; k < 4; k++)
                    acc += int'(tap[k][8*c +: 8]) * wt[k];
                acc = (acc + (1 << (2*FRAC - 1))) >> (2*FRAC);
                if (acc > 255)
                    acc = 255;
                res[8*c +: 8] = acc[7:0];
            end
            return res;
        endfunction

        function void take_item(logic cmd, logic [8:0] col, logic [7:0] row,
                                logic [31:0] pixel, logic signed [17:0] sx,
                                logic signed [16:0] sy);
            if (cmd == CMD_WRITE)
                image[row*STORE_W + col] = pixel;
            else
                pending_pixels.push_back(blend_pixel(sx, sy));
        endfunction

        function void check_pixel(logic [31:0] actual);
            logic [31:0] want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel_out %h", $time, actual);
                fails++;
                return;
            end
            want = pending_pixels.pop_front();
            if (actual !== want) begin
                $display("%0t: pixel_out expected %h actual %h", $time, want, actual);
                fails++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cmd;
    logic [8:0]         i_write_col;
    logic [7:0]         i_write_row;
    logic [31:0]        i_write_pixel;
    logic signed [17:0] i_sample_x;
    logic signed [16:0] i_sample_y;
    logic               o_result_valid;
    logic [31:0]        o_pixel_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    remap_predictor sb;
    bit             painted [0:STORE_W*STORE_H-1];
    int             idle_pct;
    int             phase_items;
    int             stall_cycles;

    bilinear_remap_sampler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_write_col    (i_write_col),
        .i_write_row    (i_write_row),
        .i_write_pixel  (i_write_pixel),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .o_result_valid (o_result_valid),
        .o_pixel_out    (o_pixel_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.take_item(i_cmd, i_write_col, i_write_row, i_write_pixel,
                             i_sample_x, i_sample_y);
            if (o_result_valid === 1'b1)
                sb.check_pixel(o_pixel_out);
        end
    end

    // abort if nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid === 1'b1 || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(logic cmd, int col, int row, logic [31:0] pixel,
                             int sx, int sy);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_write_col   <= col[8:0];
        i_write_row   <= row[7:0];
        i_write_pixel <= pixel;
        i_sample_x    <= sx[17:0];
        i_sample_y    <= sy[16:0];
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        phase_items++;
    endtask

    task automatic put_pixel(int col, int row, logic [31:0] pixel);
        painted[row*STORE_W + col] = 1'b1;
        send_item(CMD_WRITE, col, row, pixel, $urandom, $urandom);
    endtask

    // fill any tap that has never been written, then sample
    task automatic sample_at(int sx, int sy);
        int x0, y0, x1, y1, fx, fy;
        sb.locate(sx[17:0], sy[16:0], x0, y0, x1, y1, fx, fy);
        if (!painted[y0*STORE_W + x0]) put_pixel(x0, y0, $urandom);
        if (!painted[y0*STORE_W + x1]) put_pixel(x1, y0, $urandom);
        if (!painted[y1*STORE_W + x1]) put_pixel(x1, y1, $urandom);
        if (!painted[y1*STORE_W + x0]) put_pixel(x0, y1, $urandom);
        send_item(CMD_SAMPLE, $urandom_range(511), $urandom_range(255), $urandom, sx, sy);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // drop start, wait for every pending pixel, then let writes retire
    task automatic settle();
        start <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_item();
        int sx, sy, lim_x, lim_y;
        lim_x = (sb.width - 1) * ONE;
        lim_y = (sb.height - 1) * ONE;
        if ($urandom_range(99) < 20) begin
            put_pixel($urandom_range(STORE_W - 1), $urandom_range(STORE_H - 1), $urandom);
        end else begin
            if ($urandom_range(99) < 70) begin
                sx = $urandom_range(lim_x + 300) - 150;
                sy = $urandom_range(lim_y + 300) - 150;
            end else begin
                sx = $urandom_range(262143) - 131072;
                sy = $urandom_range(131071) - 65536;
            end
            if ($urandom_range(9) == 0) sx = sx & ~(ONE - 1);
            if ($urandom_range(9) == 0) sy = sy & ~(ONE - 1);
            sample_at(sx, sy);
        end
    endtask

    task automatic run_phase(int w, int h, int ch, int pct, int count);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_CHANNEL_COUNT, ch);
        idle_pct    = pct;
        phase_items = 0;
        while (phase_items < count)
            random_item();
    endtask

    initial begin
        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = CMD_WRITE;
        i_write_col   = '0;
        i_write_row   = '0;
        i_write_pixel = '0;
        i_sample_x    = '0;
        i_sample_y    = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_pct      = 32;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: corners, clamping both ways, centre and rounding
        put_pixel(0, 0, 32'hFFFF_FFFF);
        put_pixel(1, 0, 32'h0000_0000);
        put_pixel(0, 1, 32'h0101_0101);
        put_pixel(1, 1, 32'h8040_2010);
        sample_at(-131072, -65536);
        sample_at(0, 0);
        sample_at(128, 128);
        sample_at(255, 1);
        sample_at(1, 255);
        put_pixel(511, 255, 32'hA5A5_A5A5);
        put_pixel(510, 255, 32'h5A5A_5A5A);
        put_pixel(511, 254, 32'hFFFF_FFFF);
        put_pixel(510, 254, 32'h0000_0000);
        sample_at(131071, 65535);
        sample_at(510*ONE + 128, 254*ONE + 64);
        put_pixel(2, 0, 32'h0000_0000);
        put_pixel(3, 0, 32'h0101_0101);
        sample_at(2*ONE + 128, 0);
        put_pixel(4, 0, 32'hFFFF_FFFF);
        put_pixel(4, 1, 32'hFFFF_FFFF);
        put_pixel(5, 0, 32'hFFFF_FFFF);
        put_pixel(5, 1, 32'hFFFF_FFFF);
        sample_at(4*ONE + 77, 200);

        run_phase(0, 0, 0, 32, 40);
        run_phase(1023, 511, 7, 32, 120);
        run_phase(9, 5, 2, 81, 150);
        run_phase(512, 256, 4, 81, 100);
        run_phase(33, 17, 3, 0, 150);
        run_phase(2, 256, 1, 0, 90);
        settle();

        if (sb.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
